[design/knn_pkg.sv]
// ----------------------------------------------------------------------------
// knn_pkg: shared constants for the k-nearest-neighbour classifier
// Default sizes, request codes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package knn_pkg;

  // Default sizing of the training store and the vote.
  localparam int KNN_MAX_POINTS   = 256;
  localparam int KNN_MAX_FEATURES = 8;
  localparam int KNN_MAX_K        = 16;

  // Request codes.
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_TRAIN = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // Result status codes.
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NO_POINTS = 2'd1;
  localparam logic [1:0] STS_DIM_DIFF  = 2'd2;

endpackage

`default_nettype wire

[design/knn_in_if.sv]
// ----------------------------------------------------------------------------
// knn_in_if: request channel of the classifier
// Valid/ready handshake carrying one coordinate request.
// ----------------------------------------------------------------------------
`default_nettype none

interface knn_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic signed [15:0] coordinate;
  logic [15:0] label;
  logic        last_coordinate;

  modport source (output valid, req_type, coordinate, label, last_coordinate, input ready);
  modport sink   (input valid, req_type, coordinate, label, last_coordinate, output ready);
endinterface

`default_nettype wire

[design/knn_out_if.sv]
// ----------------------------------------------------------------------------
// knn_out_if: result channel of the classifier
// Valid/ready handshake carrying one classification result.
// ----------------------------------------------------------------------------
`default_nettype none

interface knn_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] predicted_label;
  logic [4:0]  vote_count;
  logic [1:0]  status;
  logic        points_dropped;

  modport source (output valid, predicted_label, vote_count, status, points_dropped,
                  input ready);
  modport sink   (input valid, predicted_label, vote_count, status, points_dropped,
                  output ready);
endinterface

`default_nettype wire

[design/knn_cfg_if.sv]
// ----------------------------------------------------------------------------
// knn_cfg_if: configuration write channel
// Valid/ready handshake carrying the neighbour count register value.
// ----------------------------------------------------------------------------
`default_nettype none

interface knn_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] neighbor_count;

  modport source (output valid, neighbor_count, input ready);
  modport sink   (input valid, neighbor_count, output ready);
endinterface

`default_nettype wire

[design/knn_sweep.sv]
// ----------------------------------------------------------------------------
// knn_sweep: coordinate store and distance accumulator
// Holds the training coordinates and the per-point partial distances, and
// sweeps all stored points for one query coordinate through a short pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_sweep import knn_pkg::*; #(
  parameter int MAX_POINTS   = KNN_MAX_POINTS,
  parameter int MAX_FEATURES = KNN_MAX_FEATURES,
  localparam int PIDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int PCNT_W = $clog2(MAX_POINTS + 1),
  localparam int FIDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
  localparam int ADDR_W = (MAX_POINTS * MAX_FEATURES > 1) ?
                          $clog2(MAX_POINTS * MAX_FEATURES) : 1,
  localparam int DIST_W = 32 + $clog2(MAX_FEATURES)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Training coordinate write.
  input  wire logic              tr_we,
  input  wire logic [ADDR_W-1:0] tr_addr,
  input  wire logic [15:0]       tr_data,
  // Query coordinate sweep.
  input  wire logic              start,
  input  wire logic [FIDX_W-1:0] q_ci,
  input  wire logic              q_first,
  input  wire logic [PCNT_W-1:0] q_count,
  input  wire logic [15:0]       q_coord,
  output      logic              busy,
  // Distance read port for the selection unit.
  input  wire logic [PIDX_W-1:0] rd_addr,
  output      logic [DIST_W-1:0] rd_data
);

  logic [15:0]       coord_mem [MAX_POINTS*MAX_FEATURES];
  logic [DIST_W-1:0] dist_mem  [MAX_POINTS];

  logic              run_r;
  logic [PCNT_W-1:0] idx_r;
  logic [PCNT_W-1:0] cnt_r;
  logic [FIDX_W-1:0] ci_r;
  logic              first_r;
  logic [15:0]       qc_r;

  logic              v1_r;
  logic [PIDX_W-1:0] idx1_r;
  logic [15:0]       coord_q_r;
  logic [DIST_W-1:0] dist_q_r;

  logic              v2_r;
  logic [PIDX_W-1:0] idx2_r;
  logic [31:0]       sq2_r;
  logic [DIST_W-1:0] d2_r;

  logic              issue;
  logic [ADDR_W-1:0] c_addr;
  logic [PIDX_W-1:0] d_addr;
  logic signed [16:0] diff;
  logic [15:0]       absd;

  // Issue one point per cycle while the sweep runs.
  assign issue  = run_r && (idx_r < cnt_r);
  assign c_addr = ADDR_W'(idx_r[PIDX_W-1:0]) * ADDR_W'(MAX_FEATURES) + ADDR_W'(ci_r);
  assign d_addr = run_r ? idx_r[PIDX_W-1:0] : rd_addr;
  assign busy   = run_r || v1_r || v2_r;
  assign rd_data = dist_q_r;

  // Coordinate memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (tr_we) begin
      coord_mem[tr_addr] <= tr_data;
    end
    coord_q_r <= coord_mem[c_addr];
  end

  // Distance memory: write-back from the last stage, registered read.
  // Each point is visited once per sweep, so a write never meets a read
  // of the same entry.
  always_ff @(posedge clk) begin
    if (v2_r) begin
      dist_mem[idx2_r] <= d2_r + DIST_W'(sq2_r);
    end
    dist_q_r <= dist_mem[d_addr];
  end

  // Absolute difference of the query and stored coordinate.
  always_comb begin
    diff = $signed({qc_r[15], qc_r}) - $signed({coord_q_r[15], coord_q_r});
    absd = diff[16] ? 16'(-diff) : diff[15:0];
  end

  // Sweep control and pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && !issue) begin
        run_r <= 1'b0;
      end
    end
  end

  // Sweep payload: latch the command, step the index, square and carry.
  always_ff @(posedge clk) begin
    if (start) begin
      idx_r   <= '0;
      cnt_r   <= q_count;
      ci_r    <= q_ci;
      first_r <= q_first;
      qc_r    <= q_coord;
    end else if (issue) begin
      idx_r <= idx_r + 1'b1;
    end
    idx1_r <= idx_r[PIDX_W-1:0];
    idx2_r <= idx1_r;
    sq2_r  <= absd * absd;
    d2_r   <= first_r ? '0 : dist_q_r;
  end

endmodule

`default_nettype wire

[design/knn_select.sv]
// ----------------------------------------------------------------------------
// knn_select: nearest-neighbour selection and majority vote
// Holds the training labels. Picks the k nearest points one round at a time
// by scanning the distance store, tallies their labels, then picks the winner.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_select import knn_pkg::*; #(
  parameter int MAX_POINTS   = KNN_MAX_POINTS,
  parameter int MAX_FEATURES = KNN_MAX_FEATURES,
  parameter int MAX_K        = KNN_MAX_K,
  localparam int PIDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int PCNT_W = $clog2(MAX_POINTS + 1),
  localparam int K_W    = $clog2(MAX_K + 1),
  localparam int KIDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1,
  localparam int DIST_W = 32 + $clog2(MAX_FEATURES)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Label write.
  input  wire logic              lab_we,
  input  wire logic [PIDX_W-1:0] lab_waddr,
  input  wire logic [15:0]       lab_wdata,
  // Classification command.
  input  wire logic              start,
  input  wire logic [K_W-1:0]    k,
  input  wire logic [PCNT_W-1:0] count,
  // Distance store read.
  output      logic [PIDX_W-1:0] dist_addr,
  input  wire logic [DIST_W-1:0] dist_data,
  // Result.
  output      logic              done,
  output      logic [15:0]       win_label,
  output      logic [K_W-1:0]    win_votes
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAB, S_VOTE, S_PICK} sel_state_t;

  logic [15:0]       label_mem [MAX_POINTS];
  logic [15:0]       lab_q_r;

  sel_state_t        state_r;
  logic              done_r;
  logic [PCNT_W-1:0] idx_r;
  logic [PCNT_W-1:0] cnt_r;
  logic [K_W-1:0]    k_r;
  logic              dv_r;
  logic [PIDX_W-1:0] didx_r;
  logic              found_r;
  logic [DIST_W-1:0] best_d_r;
  logic [PIDX_W-1:0] best_i_r;
  logic              have_prev_r;
  logic [DIST_W-1:0] prev_d_r;
  logic [PIDX_W-1:0] prev_i_r;
  logic [K_W-1:0]    round_r;
  logic [K_W-1:0]    nlab_r;
  logic [15:0]       labs_r  [MAX_K];
  logic [K_W-1:0]    votes_r [MAX_K];
  logic [K_W-1:0]    pick_r;
  logic [K_W-1:0]    bestv_r;
  logic [KIDX_W-1:0] besti_r;

  logic              hit;
  logic [KIDX_W-1:0] hit_j;
  logic              elig;

  assign dist_addr = idx_r[PIDX_W-1:0];
  assign done      = done_r;
  assign win_label = labs_r[besti_r];
  assign win_votes = bestv_r;

  // A point is still free when it ranks after the previous pick, ordered by
  // distance and then by index.
  assign elig = !have_prev_r || (dist_data > prev_d_r) ||
                ((dist_data == prev_d_r) && (didx_r > prev_i_r));

  // Label memory: written on a stored point, read at the chosen neighbour.
  always_ff @(posedge clk) begin
    if (lab_we) begin
      label_mem[lab_waddr] <= lab_wdata;
    end
    lab_q_r <= label_mem[best_i_r];
  end

  // Look for the neighbour's label among those already met.
  always_comb begin
    hit   = 1'b0;
    hit_j = '0;
    for (int j = 0; j < MAX_K; j++) begin
      if (!hit && (K_W'(j) < nlab_r) && (labs_r[j] == lab_q_r)) begin
        hit   = 1'b1;
        hit_j = KIDX_W'(j);
      end
    end
  end

  // Selection sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      dv_r    <= 1'b0;
    end else begin
      done_r <= (state_r == S_PICK) && !(pick_r < nlab_r);
      case (state_r)
        S_IDLE: begin
          if (start) begin
            have_prev_r <= 1'b0;
            k_r     <= k;
            cnt_r   <= count;
            round_r <= '0;
            nlab_r  <= '0;
            idx_r   <= '0;
            found_r <= 1'b0;
            dv_r    <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Strict compare keeps the lower index on equal distances.
          if (dv_r && elig && (!found_r || (dist_data < best_d_r))) begin
            found_r  <= 1'b1;
            best_d_r <= dist_data;
            best_i_r <= didx_r;
          end
          dv_r   <= (idx_r < cnt_r);
          didx_r <= idx_r[PIDX_W-1:0];
          if (idx_r < cnt_r) begin
            idx_r <= idx_r + 1'b1;
          end else if (!dv_r) begin
            have_prev_r <= 1'b1;
            prev_d_r    <= best_d_r;
            prev_i_r    <= best_i_r;
            state_r     <= S_LAB;
          end
        end
        S_LAB: begin
          state_r <= S_VOTE;
        end
        S_VOTE: begin
          if (hit) begin
            votes_r[hit_j] <= votes_r[hit_j] + 1'b1;
          end else begin
            labs_r[nlab_r[KIDX_W-1:0]]  <= lab_q_r;
            votes_r[nlab_r[KIDX_W-1:0]] <= K_W'(1);
            nlab_r <= nlab_r + 1'b1;
          end
          round_r <= round_r + 1'b1;
          if (round_r + 1'b1 == k_r) begin
            pick_r  <= '0;
            bestv_r <= '0;
            besti_r <= '0;
            state_r <= S_PICK;
          end else begin
            idx_r   <= '0;
            found_r <= 1'b0;
            dv_r    <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_PICK: begin
          // First label with the highest tally wins.
          if (pick_r < nlab_r) begin
            if (votes_r[pick_r[KIDX_W-1:0]] > bestv_r) begin
              bestv_r <= votes_r[pick_r[KIDX_W-1:0]];
              besti_r <= pick_r[KIDX_W-1:0];
            end
            pick_r <= pick_r + 1'b1;
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/knn_majority_classifier.sv]
// ----------------------------------------------------------------------------
// knn_majority_classifier: k-nearest-neighbour majority classifier
// Stores labelled training points and answers queries with the majority
// label of the k nearest points under squared Euclidean distance.
// ----------------------------------------------------------------------------
// Clear and training requests are handled on acceptance in the idle state;
// a query coordinate sweeps the distance memory over the N stored points.
// The last query coordinate adds the selection scans over the distance memory,
// one per neighbour, and a pick over the distinct labels before the output.
// One request is in progress at a time; the result register lets the next
// request in while a result waits. Synchronous active-low reset empties the set.
`default_nettype none

module knn_majority_classifier import knn_pkg::*; #(
  parameter int MAX_POINTS   = KNN_MAX_POINTS,
  parameter int MAX_FEATURES = KNN_MAX_FEATURES,
  parameter int MAX_K        = KNN_MAX_K
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  knn_in_if.sink      in_ch,
  knn_out_if.source   out_ch,
  knn_cfg_if.sink     cfg_ch
);

  localparam int PIDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PCNT_W = $clog2(MAX_POINTS + 1);
  localparam int FIDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CI_W   = $clog2(MAX_FEATURES + 2);
  localparam int K_W    = $clog2(MAX_K + 1);
  localparam int ADDR_W = (MAX_POINTS * MAX_FEATURES > 1) ?
                          $clog2(MAX_POINTS * MAX_FEATURES) : 1;
  localparam int DIST_W = 32 + $clog2(MAX_FEATURES);

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_SEL, ST_PUSH} state_t;

  state_t            state_r;
  logic [CI_W-1:0]   coord_idx_r;
  logic [CI_W-1:0]   dim_r;
  logic [PCNT_W-1:0] pcount_r;
  logic              ovf_r;
  logic              inq_r;
  logic [4:0]        nbr_r;
  logic              pend_last_r;
  logic [1:0]        res_status_r;
  logic [15:0]       res_label_r;
  logic [4:0]        res_votes_r;
  logic              out_valid_r;
  logic [15:0]       out_label_r;
  logic [4:0]        out_votes_r;
  logic [1:0]        out_status_r;
  logic              out_drop_r;

  logic              acc;
  logic              is_q;
  logic [CI_W-1:0]   ci_eff;
  logic [CI_W-1:0]   ci_inc;
  logic              pt_ok;
  logic              room;
  logic              sweep_go;
  logic [1:0]        q_status;
  logic              tr_we;
  logic [ADDR_W-1:0] tr_addr;
  logic              lab_we;
  logic              sweep_start;
  logic              sweep_busy;
  logic              sel_start;
  logic              sel_done;
  logic [15:0]       win_label;
  logic [K_W-1:0]    win_votes;
  logic [K_W-1:0]    k_sel;
  logic [PIDX_W-1:0] dist_addr;
  logic [DIST_W-1:0] dist_data;
  int unsigned       kt;

  // Handshakes.
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign acc          = in_ch.valid && in_ch.ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.predicted_label = out_label_r;
  assign out_ch.vote_count      = out_votes_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.points_dropped  = out_drop_r;

  // Coordinate position of this request; a change of kind restarts the point.
  always_comb begin
    is_q     = (in_ch.req_type == REQ_QUERY);
    ci_eff   = ((coord_idx_r != '0) && (inq_r != is_q)) ? '0 : coord_idx_r;
    ci_inc   = (ci_eff <= CI_W'(MAX_FEATURES)) ? ci_eff + 1'b1 : ci_eff;
    room     = (pcount_r < PCNT_W'(MAX_POINTS));
    pt_ok    = (ci_inc >= CI_W'(1)) && (ci_inc <= CI_W'(MAX_FEATURES)) &&
               ((dim_r == '0) || (ci_inc == dim_r));
    sweep_go = (ci_eff < dim_r) && (ci_eff < CI_W'(MAX_FEATURES)) && (pcount_r != '0);
    if (pcount_r == '0) begin
      q_status = STS_NO_POINTS;
    end else if (ci_inc != dim_r) begin
      q_status = STS_DIM_DIFF;
    end else begin
      q_status = STS_OK;
    end
  end

  // Store writes and unit starts.
  assign tr_addr = ADDR_W'(pcount_r[PIDX_W-1:0]) * ADDR_W'(MAX_FEATURES) + ADDR_W'(ci_eff);
  assign tr_we   = acc && (in_ch.req_type == REQ_TRAIN) && room &&
                   (ci_eff < CI_W'(MAX_FEATURES));
  assign lab_we  = acc && (in_ch.req_type == REQ_TRAIN) && in_ch.last_coordinate &&
                   pt_ok && room;
  assign sweep_start = acc && is_q && sweep_go;
  assign sel_start   = (state_r == ST_SWEEP) && !sweep_busy && pend_last_r &&
                       (res_status_r == STS_OK);

  // Neighbour count: zero counts as one, limited by MAX_K and the stored points.
  always_comb begin
    kt = (nbr_r == '0) ? 1 : 32'(nbr_r);
    if (kt > MAX_K) begin
      kt = MAX_K;
    end
    if (kt > 32'(pcount_r)) begin
      kt = 32'(pcount_r);
    end
    k_sel = K_W'(kt);
  end

  knn_sweep #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_sweep (
    .clk     (clk),
    .rst_n   (rst_n),
    .tr_we   (tr_we),
    .tr_addr (tr_addr),
    .tr_data (in_ch.coordinate),
    .start   (sweep_start),
    .q_ci    (ci_eff[FIDX_W-1:0]),
    .q_first (ci_eff == '0),
    .q_count (pcount_r),
    .q_coord (in_ch.coordinate),
    .busy    (sweep_busy),
    .rd_addr (dist_addr),
    .rd_data (dist_data)
  );

  knn_select #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_K        (MAX_K)
  ) u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .lab_we    (lab_we),
    .lab_waddr (pcount_r[PIDX_W-1:0]),
    .lab_wdata (in_ch.label),
    .start     (sel_start),
    .k         (k_sel),
    .count     (pcount_r),
    .dist_addr (dist_addr),
    .dist_data (dist_data),
    .done      (sel_done),
    .win_label (win_label),
    .win_votes (win_votes)
  );

  // Control sequencer, training set bookkeeping and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      coord_idx_r <= '0;
      dim_r       <= '0;
      pcount_r    <= '0;
      ovf_r       <= 1'b0;
      inq_r       <= 1'b0;
      nbr_r       <= 5'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        nbr_r <= cfg_ch.neighbor_count;
      end
      // The push phase reloads the result register itself.
      if (out_valid_r && out_ch.ready && (state_r != ST_PUSH)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (acc) begin
            case (in_ch.req_type)
              REQ_CLEAR: begin
                pcount_r    <= '0;
                dim_r       <= '0;
                coord_idx_r <= '0;
                ovf_r       <= 1'b0;
                inq_r       <= 1'b0;
              end
              REQ_TRAIN: begin
                inq_r       <= 1'b0;
                coord_idx_r <= in_ch.last_coordinate ? '0 : ci_inc;
                if (in_ch.last_coordinate && pt_ok) begin
                  if (room) begin
                    pcount_r <= pcount_r + 1'b1;
                    dim_r    <= ci_inc;
                  end else begin
                    ovf_r <= 1'b1;
                  end
                end
              end
              REQ_QUERY: begin
                inq_r        <= !in_ch.last_coordinate;
                coord_idx_r  <= in_ch.last_coordinate ? '0 : ci_inc;
                pend_last_r  <= in_ch.last_coordinate;
                res_status_r <= q_status;
                res_label_r  <= '0;
                res_votes_r  <= '0;
                if (sweep_go) begin
                  state_r <= ST_SWEEP;
                end else if (in_ch.last_coordinate) begin
                  state_r <= ST_PUSH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SWEEP: begin
          if (!sweep_busy) begin
            if (!pend_last_r) begin
              state_r <= ST_IDLE;
            end else if (res_status_r == STS_OK) begin
              state_r <= ST_SEL;
            end else begin
              state_r <= ST_PUSH;
            end
          end
        end
        ST_SEL: begin
          if (sel_done) begin
            res_label_r <= win_label;
            res_votes_r <= 5'(win_votes);
            state_r     <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_label_r  <= res_label_r;
            out_votes_r  <= res_votes_r;
            out_status_r <= res_status_r;
            out_drop_r   <= ovf_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // A stored point always fixes the dimension, and a clear drops both.
  a_dim_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pcount_r == '0) == (dim_r == '0))
    else $error("dimension and point count disagree");

  // The coordinate count saturates one past the feature limit.
  a_coord_sat: assert property (@(posedge clk) disable iff (!rst_n)
    coord_idx_r <= CI_W'(MAX_FEATURES + 1))
    else $error("coordinate index beyond saturation");

  // Selection only finishes while the sequencer waits for it.
  a_sel_done: assert property (@(posedge clk) disable iff (!rst_n)
    sel_done |-> (state_r == ST_SEL))
    else $error("selection finished outside the selection phase");

  // The point count never exceeds capacity.
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pcount_r <= PCNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

endmodule

`default_nettype wire

[test/knn_majority_classifier_tb.sv]
// ----------------------------------------------------------------------------
// knn_majority_classifier_tb: self-checking bench for the k-NN classifier
// A short table of directed requests covers the empty set, coordinate
// extremes, dimension errors and the reserved request code. Random training
// sets and queries follow. Every request is mirrored in a behavioural
// classifier, whose answers, or the fixed directed results, are compared with the block.
// ----------------------------------------------------------------------------
`default_nettype none

module knn_majority_classifier_tb;
  import knn_pkg::*;

  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam int NPTS  = KNN_MAX_POINTS;
  localparam int NFEAT = KNN_MAX_FEATURES;
  localparam int NK    = KNN_MAX_K;
  localparam int RANDOM_REQUESTS = 1950;

  typedef struct packed {
    logic [15:0] label;
    logic [4:0]  votes;
    logic [1:0]  status;
    logic        dropped;
  } knn_result_t;

  typedef struct {
    logic [1:0]         req;
    logic signed [15:0] coord;
    logic [15:0]        label;
    bit                 last;
    bit                 typed;
    knn_result_t        result;
  } req_row_t;

  logic clk = 1'b0;
  logic rst_n;

  knn_in_if  in_if();
  knn_out_if out_if();
  knn_cfg_if cfg_if();

  knn_majority_classifier DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  always #1 clk = ~clk;

  // Shadow copy of the classifier state.
  logic [15:0]     shadow_coords[NPTS][NFEAT];
  logic [15:0]     shadow_labels[NPTS];
  longint unsigned shadow_dist[NPTS];
  int unsigned     shadow_npts;
  int unsigned     shadow_dim;
  int unsigned     shadow_cidx;
  bit              shadow_overflow;
  bit              shadow_in_query;
  logic [4:0]      shadow_k;

  knn_result_t pending_results[$];
  req_row_t    directed_rows[$];
  int          mismatches;
  int          results_seen;
  int          requests_sent;
  bit          burst_mode;

  // Apply one request to the shadow state; returns 1 when a result is due.
  function automatic bit classify_step(input logic [1:0] req, input logic signed [15:0] coord,
                                       input logic [15:0] label, input bit last,
                                       output knn_result_t res);
    int unsigned ci, n, kk, nlab, best, bestv, sel;
    int          d;
    bit          found;
    bit          taken[NPTS];
    logic [15:0] labs[NK];
    int unsigned votes[NK];
    res = '0;
    if (req == REQ_RESERVED) return 0;
    if (req == REQ_CLEAR) begin
      shadow_npts = 0;
      shadow_dim = 0;
      shadow_cidx = 0;
      shadow_overflow = 0;
      shadow_in_query = 0;
      return 0;
    end
    // A change of request type abandons the unfinished point.
    if (shadow_cidx != 0 && shadow_in_query != (req == REQ_QUERY)) shadow_cidx = 0;
    shadow_in_query = (req == REQ_QUERY);
    ci = shadow_cidx;
    if (shadow_cidx <= NFEAT) shadow_cidx++;

    if (req == REQ_TRAIN) begin
      if (shadow_npts < NPTS && ci < NFEAT) shadow_coords[shadow_npts][ci] = coord;
      if (last) begin
        n = shadow_cidx;
        shadow_cidx = 0;
        if (n >= 1 && n <= NFEAT && (shadow_dim == 0 || n == shadow_dim)) begin
          if (shadow_npts < NPTS) begin
            shadow_labels[shadow_npts] = label;
            shadow_npts++;
            shadow_dim = n;
          end else begin
            shadow_overflow = 1;
          end
        end
      end
      return 0;
    end

    // Query coordinate: accumulate squared differences.
    if (ci == 0) begin
      for (int i = 0; i < NPTS; i++) shadow_dist[i] = 0;
    end
    if (ci < shadow_dim && ci < NFEAT) begin
      for (int i = 0; i < shadow_npts; i++) begin
        d = int'(coord) - int'($signed(shadow_coords[i][ci]));
        if (d < 0) d = -d;
        shadow_dist[i] += longint'(d) * longint'(d);
      end
    end
    if (!last) return 0;

    // Last coordinate: select the nearest points and count votes.
    res.dropped = shadow_overflow;
    if (shadow_npts == 0) begin
      res.status = STS_NO_POINTS;
    end else if (shadow_cidx != shadow_dim) begin
      res.status = STS_DIM_DIFF;
    end else begin
      res.status = STS_OK;
      kk = (shadow_k == 0) ? 1 : shadow_k;
      if (kk > NK) kk = NK;
      if (kk > shadow_npts) kk = shadow_npts;
      nlab = 0;
      for (int i = 0; i < NPTS; i++) taken[i] = 0;
      for (int r = 0; r < kk; r++) begin
        sel = 0;
        found = 0;
        for (int i = 0; i < shadow_npts; i++) begin
          if (!taken[i] && (!found || shadow_dist[i] < shadow_dist[sel])) begin
            sel = i;
            found = 1;
          end
        end
        taken[sel] = 1;
        found = 0;
        for (int j = 0; j < nlab; j++) begin
          if (!found && labs[j] == shadow_labels[sel]) begin
            votes[j]++;
            found = 1;
          end
        end
        if (!found) begin
          labs[nlab] = shadow_labels[sel];
          votes[nlab] = 1;
          nlab++;
        end
      end
      best = 0;
      bestv = 0;
      for (int i = 0; i < nlab; i++) begin
        if (votes[i] > bestv) begin
          bestv = votes[i];
          best = i;
        end
      end
      res.label = labs[best];
      res.votes = bestv[4:0];
    end
    shadow_cidx = 0;
    shadow_in_query = 0;
    return 1;
  endfunction

  function automatic void add_row(input logic [1:0] req, input logic signed [15:0] coord,
                                  input logic [15:0] label, input bit last, input bit typed,
                                  input logic [15:0] xlabel, input logic [4:0] xvotes,
                                  input logic [1:0] xstatus);
    req_row_t row;
    row.req = req;
    row.coord = coord;
    row.label = label;
    row.last = last;
    row.typed = typed;
    row.result = '{label: xlabel, votes: xvotes, status: xstatus, dropped: 1'b0};
    directed_rows = {directed_rows, row};
  endfunction

  function automatic int pick_gap();
    if (burst_mode) return 0;
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Offer one request and wait for it to be taken; valid stays high after
  // acceptance so back-to-back requests need no second assignment.
  task automatic send_request(input logic [1:0] req, input logic signed [15:0] coord,
                              input logic [15:0] label, input bit last, input bit typed,
                              input knn_result_t typed_result);
    int          gap;
    bit          due;
    knn_result_t res;
    knn_result_t want;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= req;
    in_if.coordinate <= coord;
    in_if.label <= label;
    in_if.last_coordinate <= last;
    do @(posedge clk); while (!in_if.ready);
    due = classify_step(req, coord, label, last, res);
    want = typed ? typed_result : res;
    if (due) pending_results = {pending_results, want};
    if (req != REQ_RESERVED) requests_sent++;
  endtask

  task automatic random_request(input logic [1:0] req, input bit narrow, input bit last,
                                input bit few_labels);
    logic signed [15:0] coord;
    logic [15:0] label;
    coord = narrow ? 16'($signed($urandom_range(0, 6)) - 3) : 16'($urandom);
    label = few_labels ? 16'($urandom_range(0, 3)) : 16'($urandom);
    send_request(req, coord, label, last, 1'b0, '0);
  endtask

  // Register writes wait until the block has drained.
  task automatic write_neighbor_count(input logic [4:0] value);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.neighbor_count <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    shadow_k = value;
  endtask

  // Result checking against the oldest prediction.
  always @(posedge clk) begin
    knn_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result label=%0d", out_if.predicted_label);
      end else begin
        want = pending_results.pop_front();
        if (out_if.predicted_label !== want.label || out_if.vote_count !== want.votes ||
            out_if.status !== want.status || out_if.points_dropped !== want.dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected label=%0d votes=%0d status=%0d dropped=%0d, %s",
                     want.label, want.votes, want.status, want.dropped,
                     $sformatf("got %0d %0d %0d %0d", out_if.predicted_label,
                               out_if.vote_count, out_if.status, out_if.points_dropped));
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off to back the block up.
  initial begin
    bit held;
    held = 0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && results_seen >= 40) begin
        held = 1;
        out_if.ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
      else repeat ($urandom_range(1, 20)) @(posedge clk);
      out_if.ready <= 1'b0;
      if ($urandom_range(0, 7) != 0) repeat ($urandom_range(1, 3)) @(posedge clk);
      else repeat ($urandom_range(10, 50)) @(posedge clk);
    end
  end

  // Stimulus.
  initial begin
    logic [4:0] k_steps[4] = '{5'd16, 5'd0, 5'd31, 5'd1};
    int episode, npoints, dimension, qcount, qlen, plen;
    bit narrow, few_labels;
    mismatches = 0;
    results_seen = 0;
    requests_sent = 0;
    burst_mode = 0;
    shadow_npts = 0;
    shadow_dim = 0;
    shadow_cidx = 0;
    shadow_overflow = 0;
    shadow_in_query = 0;
    shadow_k = 5'd1;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.req_type <= REQ_CLEAR;
    in_if.coordinate <= '0;
    in_if.label <= '0;
    in_if.last_coordinate <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.neighbor_count <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: empty set, extremes, dimension errors, reserved code.
    add_row(REQ_QUERY, 16'sd0, 16'd0, 1, 1, 16'd0, 5'd0, STS_NO_POINTS);
    add_row(REQ_RESERVED, 16'sd5, 16'd9, 1, 0, '0, '0, STS_OK);
    add_row(REQ_TRAIN, 16'sh7fff, 16'd0, 0, 0, '0, '0, STS_OK);
    add_row(REQ_TRAIN, 16'sh8000, 16'hffff, 1, 0, '0, '0, STS_OK);
    add_row(REQ_TRAIN, 16'sd1, 16'd5, 1, 0, '0, '0, STS_OK);
    add_row(REQ_TRAIN, 16'sh8000, 16'd0, 0, 0, '0, '0, STS_OK);
    add_row(REQ_TRAIN, 16'sh7fff, 16'd0, 1, 0, '0, '0, STS_OK);
    add_row(REQ_QUERY, 16'sh7fff, 16'd0, 0, 0, '0, '0, STS_OK);
    add_row(REQ_QUERY, 16'sh8000, 16'd0, 1, 1, 16'hffff, 5'd1, STS_OK);
    add_row(REQ_QUERY, 16'sd3, 16'd0, 1, 1, 16'd0, 5'd0, STS_DIM_DIFF);
    // A query with more coordinates than the store can hold.
    for (int i = 0; i < 8; i++) add_row(REQ_QUERY, 16'(i * 4000), 16'd0, 0, 0, '0, '0, STS_OK);
    add_row(REQ_QUERY, 16'sh7fff, 16'd0, 1, 1, 16'd0, 5'd0, STS_DIM_DIFF);
    // Training point abandoned by a query coordinate.
    add_row(REQ_TRAIN, 16'sd7, 16'd1, 0, 0, '0, '0, STS_OK);
    add_row(REQ_QUERY, 16'sd7, 16'd0, 1, 1, 16'd0, 5'd0, STS_DIM_DIFF);
    add_row(REQ_CLEAR, 16'sd0, 16'd0, 0, 0, '0, '0, STS_OK);
    add_row(REQ_QUERY, 16'sd0, 16'd0, 1, 1, 16'd0, 5'd0, STS_NO_POINTS);
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].coord, directed_rows[i].label,
                   directed_rows[i].last, directed_rows[i].typed, directed_rows[i].result);

    // Random episodes: a training set, then queries against it.
    episode = 0;
    while (requests_sent < RANDOM_REQUESTS + directed_rows.size()) begin
      if (episode < 4) write_neighbor_count(k_steps[episode]);
      else if ($urandom_range(0, 3) == 0) write_neighbor_count(5'($urandom_range(0, 31)));
      burst_mode = ($urandom_range(0, 4) == 0);
      narrow = $urandom_range(0, 1);
      few_labels = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) != 0 || episode == 6)
        send_request(REQ_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom), 0, '0);
      if (episode == 6 || $urandom_range(0, 40) == 0) begin
        npoints = $urandom_range(250, 262);
        dimension = 1;
      end else begin
        npoints = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 24);
        dimension = $urandom_range(1, NFEAT);
      end
      for (int p = 0; p < npoints; p++) begin
        if ($urandom_range(0, 15) == 0) random_request(REQ_QUERY, narrow, 0, few_labels);
        if ($urandom_range(0, 19) == 0) random_request(REQ_RESERVED, narrow, 1'($urandom), 0);
        plen = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 10) : dimension;
        for (int c = 0; c < plen; c++)
          random_request(REQ_TRAIN, narrow, c == plen - 1, few_labels);
      end
      qcount = $urandom_range(1, 6);
      for (int q = 0; q < qcount; q++) begin
        qlen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : dimension;
        for (int c = 0; c < qlen; c++) random_request(REQ_QUERY, narrow, c == qlen - 1, 0);
      end
      episode++;
    end
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
design/knn_pkg.sv
design/knn_in_if.sv
design/knn_out_if.sv
design/knn_cfg_if.sv
design/knn_sweep.sv
design/knn_select.sv
design/knn_majority_classifier.sv
test/knn_majority_classifier_tb.sv
